/* rtl/swi_pkg.sv */
package swi_pkg;

  // Default geometry of the coordinate format
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Queue between classification and solve sections
  localparam int FIFO_DEPTH = 4;

  // Parallel tolerance: |det| below 1e-6 of the line scale
  localparam int TOL_DEN = 1000000;

  // Miss marker in whole coordinate units
  localparam int SENTINEL_UNITS = 100;

  // Configuration register indexes
  localparam int IDX_W = 2;
  typedef logic [IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_WALL_SX = 2'd0;
  localparam reg_idx_t REG_WALL_SY = 2'd1;
  localparam reg_idx_t REG_WALL_EX = 2'd2;
  localparam reg_idx_t REG_WALL_EY = 2'd3;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_HIT      = 2'd0;
  localparam status_t ST_PARALLEL = 2'd1;
  localparam status_t ST_BEYOND   = 2'd2;

  // Miss marker, saturated to the largest coordinate
  function automatic logic [63:0] sentinel(input int cw, input int fb);
    logic [63:0] full_v;
    logic [63:0] maxc;
    full_v = 64'(SENTINEL_UNITS) << fb;
    maxc   = (64'd1 << (cw - 1)) - 64'd1;
    return (full_v > maxc) ? maxc : full_v;
  endfunction

  // Width of one record in the queue: par, nx, ny, det, tx, ty, len2
  function automatic int rec_width(input int w);
    return 1 + 2 * (3 * w + 4) + (2 * w + 3) + 2 * w + (2 * w + 3);
  endfunction

endpackage

/* rtl/swi_in_if.sv */
interface swi_in_if #(
  parameter int W = swi_pkg::COORD_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] from_x;
  logic signed [W-1:0] from_y;
  logic signed [W-1:0] to_x;
  logic signed [W-1:0] to_y;

  modport source(output valid, output from_x, output from_y, output to_x, output to_y,
                 input ready);
  modport sink(input valid, input from_x, input from_y, input to_x, input to_y,
               output ready);
endinterface

/* rtl/swi_out_if.sv */
interface swi_out_if #(
  parameter int W = swi_pkg::COORD_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  swi_pkg::status_t    status;
  logic signed [W-1:0] cross_x;
  logic signed [W-1:0] cross_y;

  modport source(output valid, output status, output cross_x, output cross_y,
                 input ready);
  modport sink(input valid, input status, input cross_x, input cross_y,
               output ready);
endinterface

/* rtl/swi_cfg_if.sv */
interface swi_cfg_if #(
  parameter int W = swi_pkg::COORD_WIDTH_DEF
);
  logic              valid;
  logic              ready;
  swi_pkg::reg_idx_t index;
  logic [W-1:0]      data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

/* rtl/segment_wall_intersection.sv */
// Throughput: one segment per cycle unless the output stalls; the bit-per-stage pipelined
// dividers and the per-stage multipliers all accept a new operand set every enabled cycle.
// A four-entry queue between classification and solve sections absorbs output stalls.
// Reset (rst_n low, synchronous) clears all valid flags, the queue and the wall
// registers (all four end-point coordinates to zero).
module segment_wall_intersection #(
  parameter int COORD_WIDTH = swi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = swi_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  swi_in_if.sink     in_chan,
  swi_out_if.source  out_chan,
  swi_cfg_if.sink    cfg_chan
);
  import swi_pkg::*;

  localparam int REC_W = rec_width(COORD_WIDTH);
  localparam logic [COORD_WIDTH-1:0] SENT = COORD_WIDTH'(sentinel(COORD_WIDTH, FRAC_BITS));

  // Wall end points
  logic [3:0][COORD_WIDTH-1:0] wall_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_r <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_WALL_SX: wall_r[REG_WALL_SX] <= COORD_WIDTH'(cfg_chan.data);
        REG_WALL_SY: wall_r[REG_WALL_SY] <= COORD_WIDTH'(cfg_chan.data);
        REG_WALL_EX: wall_r[REG_WALL_EX] <= COORD_WIDTH'(cfg_chan.data);
        REG_WALL_EY: wall_r[REG_WALL_EY] <= COORD_WIDTH'(cfg_chan.data);
        default: ;
      endcase
    end
  end

  logic             f_valid, f_ready;
  logic [REC_W-1:0] f_data, q_data;
  logic             fifo_full, fifo_empty;
  logic             b_ready;

  swi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .from_x    (in_chan.from_x),
    .from_y    (in_chan.from_y),
    .to_x      (in_chan.to_x),
    .to_y      (in_chan.to_y),
    .wall      (wall_r),
    .rec_valid (f_valid),
    .rec_ready (f_ready),
    .rec_data  (f_data)
  );

  assign f_ready = !fifo_full;

  swi_fifo #(.DATA_W(REC_W), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_valid && !fifo_full),
    .wdata (f_data),
    .pop   (b_ready && !fifo_empty),
    .rdata (q_data),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  swi_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .rec_valid   (!fifo_empty),
    .rec_ready   (b_ready),
    .rec_data    (q_data),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_status  (out_chan.status),
    .out_cross_x (out_chan.cross_x),
    .out_cross_y (out_chan.cross_y)
  );

`ifndef SYNTHESIS
  a_fifo_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_full && fifo_empty))
    else $error("queue reports full and empty at once");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.status == ST_HIT || out_chan.status == ST_PARALLEL ||
                        out_chan.status == ST_BEYOND))
    else $error("undefined status code on result");

  a_miss_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status != ST_HIT) |->
      (out_chan.cross_x == $signed(SENT) && out_chan.cross_y == $signed(SENT)))
    else $error("miss result without sentinel coordinates");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");
`endif
endmodule

/* rtl/swi_fifo.sv */
module swi_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = swi_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              full,
  output logic              empty
);
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wptr_r;
  logic [AW-1:0]     rptr_r;
  logic [CNTW-1:0]   cnt_r;

  // Store on transfer in
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  assign rdata = mem_r[rptr_r];
  assign full  = (cnt_r == CNTW'(DEPTH));
  assign empty = (cnt_r == '0);
endmodule

/* rtl/swi_front.sv */
module swi_front #(
  parameter int COORD_WIDTH = swi_pkg::COORD_WIDTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]                     from_x,
  input  logic signed [COORD_WIDTH-1:0]                     from_y,
  input  logic signed [COORD_WIDTH-1:0]                     to_x,
  input  logic signed [COORD_WIDTH-1:0]                     to_y,
  input  logic [3:0][COORD_WIDTH-1:0]                       wall,
  output logic                                              rec_valid,
  input  logic                                              rec_ready,
  output logic [swi_pkg::rec_width(COORD_WIDTH)-1:0]        rec_data
);
  import swi_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int DXW = W + 1;
  localparam int PW  = 2 * W + 2;
  localparam int CW  = 2 * W + 2;
  localparam int DW  = 2 * W + 3;
  localparam int PLW = 2 * W + 2;
  localparam int PHW = 2 * W + 3;
  localparam int NW  = 3 * W + 4;
  localparam int LW  = 2 * W + 22;
  localparam int L2W = 2 * W + 3;

  logic       en;
  logic [5:1] v_r;

  // Stall the whole section when the last record cannot leave
  assign en        = !v_r[5] || rec_ready;
  assign in_ready  = en;
  assign rec_valid = v_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:1], in_valid};
    end
  end

  // ---------------- Stage 1: differences and line coefficients
  logic signed [W-1:0]   wsx, wsy, wex, wey;
  logic signed [DXW-1:0] wdx_nxt, wdy_nxt, sdx_nxt, sdy_nxt;
  logic                  wvert_nxt, svert_nxt;
  logic signed [DXW-1:0] wa_nxt, wb_nxt, ws_nxt, sa_nxt, sb_nxt, ss_nxt;

  assign wsx = $signed(wall[REG_WALL_SX]);
  assign wsy = $signed(wall[REG_WALL_SY]);
  assign wex = $signed(wall[REG_WALL_EX]);
  assign wey = $signed(wall[REG_WALL_EY]);

  assign wdx_nxt   = DXW'(wex) - DXW'(wsx);
  assign wdy_nxt   = DXW'(wey) - DXW'(wsy);
  assign sdx_nxt   = DXW'(to_x) - DXW'(from_x);
  assign sdy_nxt   = DXW'(to_y) - DXW'(from_y);
  assign wvert_nxt = (wdx_nxt == '0);
  assign svert_nxt = (sdx_nxt == '0);

  // Vertical lines take a = -1, b = 0, scale 1
  assign wa_nxt = wvert_nxt ? DXW'(-1) : -wdy_nxt;
  assign wb_nxt = wvert_nxt ? '0 : wdx_nxt;
  assign ws_nxt = wvert_nxt ? DXW'(1) : wdx_nxt;
  assign sa_nxt = svert_nxt ? DXW'(-1) : -sdy_nxt;
  assign sb_nxt = svert_nxt ? '0 : sdx_nxt;
  assign ss_nxt = svert_nxt ? DXW'(1) : sdx_nxt;

  logic signed [DXW-1:0] wdx_r, wdy_r, sdx_r, sdy_r;
  logic signed [DXW-1:0] wa1_r, wb1_r, ws1_r, sa1_r, sb1_r, ss1_r;
  logic signed [W-1:0]   wx2_1_r, wy2_1_r, tx1_r, ty1_r;
  logic                  wvert1_r, svert1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wdx_r    <= wdx_nxt;
      wdy_r    <= wdy_nxt;
      sdx_r    <= sdx_nxt;
      sdy_r    <= sdy_nxt;
      wa1_r    <= wa_nxt;
      wb1_r    <= wb_nxt;
      ws1_r    <= ws_nxt;
      sa1_r    <= sa_nxt;
      sb1_r    <= sb_nxt;
      ss1_r    <= ss_nxt;
      wx2_1_r  <= wex;
      wy2_1_r  <= wey;
      tx1_r    <= to_x;
      ty1_r    <= to_y;
      wvert1_r <= wvert_nxt;
      svert1_r <= svert_nxt;
    end
  end

  // ---------------- Stage 2: first products
  logic signed [PW-1:0] wp1_nxt, wp2_nxt, sp1_nxt, sp2_nxt;
  logic signed [PW-1:0] dpa_nxt, dpb_nxt, sprod_nxt, sqx_nxt, sqy_nxt;

  assign wp1_nxt   = PW'(wdx_r) * PW'(wy2_1_r);
  assign wp2_nxt   = PW'(wdy_r) * PW'(wx2_1_r);
  assign sp1_nxt   = PW'(sdx_r) * PW'(ty1_r);
  assign sp2_nxt   = PW'(sdy_r) * PW'(tx1_r);
  assign dpa_nxt   = PW'(wa1_r) * PW'(sb1_r);
  assign dpb_nxt   = PW'(wb1_r) * PW'(sa1_r);
  assign sprod_nxt = PW'(ws1_r) * PW'(ss1_r);
  assign sqx_nxt   = PW'(sdx_r) * PW'(sdx_r);
  assign sqy_nxt   = PW'(sdy_r) * PW'(sdy_r);

  logic signed [PW-1:0]  wp1_r, wp2_r, sp1_r, sp2_r, dpa_r, dpb_r, sprod_r, sqx_r, sqy_r;
  logic signed [DXW-1:0] wa2_r, wb2_r, sa2_r, sb2_r;
  logic signed [W-1:0]   wx2_2_r, tx2_r, ty2_r;
  logic                  wvert2_r, svert2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wp1_r    <= wp1_nxt;
      wp2_r    <= wp2_nxt;
      sp1_r    <= sp1_nxt;
      sp2_r    <= sp2_nxt;
      dpa_r    <= dpa_nxt;
      dpb_r    <= dpb_nxt;
      sprod_r  <= sprod_nxt;
      sqx_r    <= sqx_nxt;
      sqy_r    <= sqy_nxt;
      wa2_r    <= wa1_r;
      wb2_r    <= wb1_r;
      sa2_r    <= sa1_r;
      sb2_r    <= sb1_r;
      wx2_2_r  <= wx2_1_r;
      tx2_r    <= tx1_r;
      ty2_r    <= ty1_r;
      wvert2_r <= wvert1_r;
      svert2_r <= svert1_r;
    end
  end

  // ---------------- Stage 3: c terms, determinant, scale and length
  logic signed [CW-1:0] wc_nxt, sc_nxt;
  logic signed [DW-1:0] det3_nxt;
  logic [PW-1:0]        rhs_nxt;
  logic [L2W-1:0]       len2_3_nxt;

  // Vertical line: c = -x of its second point
  assign wc_nxt     = wvert2_r ? -CW'(wx2_2_r) : wp1_r - wp2_r;
  assign sc_nxt     = svert2_r ? -CW'(tx2_r) : sp1_r - sp2_r;
  assign det3_nxt   = DW'(dpa_r) - DW'(dpb_r);
  assign rhs_nxt    = sprod_r[PW-1] ? $unsigned(-sprod_r) : $unsigned(sprod_r);
  assign len2_3_nxt = L2W'($unsigned(sqx_r)) + L2W'($unsigned(sqy_r));

  logic signed [CW-1:0]  wc_r, sc_r;
  logic signed [DW-1:0]  det3_r;
  logic [PW-1:0]         rhs_r;
  logic [L2W-1:0]        len2_3_r;
  logic signed [DXW-1:0] wa3_r, wb3_r, sa3_r, sb3_r;
  logic signed [W-1:0]   tx3_r, ty3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wc_r     <= wc_nxt;
      sc_r     <= sc_nxt;
      det3_r   <= det3_nxt;
      rhs_r    <= rhs_nxt;
      len2_3_r <= len2_3_nxt;
      wa3_r    <= wa2_r;
      wb3_r    <= wb2_r;
      sa3_r    <= sa2_r;
      sb3_r    <= sb2_r;
      tx3_r    <= tx2_r;
      ty3_r    <= ty2_r;
    end
  end

  // ---------------- Stage 4: parallel test and numerator partial products
  logic [DW-1:0]         detabs;
  logic                  par4_nxt;
  logic signed [W:0]     wcl, scl;
  logic signed [W+1:0]   wch, sch;
  logic signed [PLW-1:0] xwl_nxt, xsl_nxt, ywl_nxt, ysl_nxt;
  logic signed [PHW-1:0] xwh_nxt, xsh_nxt, ywh_nxt, ysh_nxt;

  assign detabs   = det3_r[DW-1] ? $unsigned(-det3_r) : $unsigned(det3_r);
  assign par4_nxt = (LW'(detabs) * LW'(TOL_DEN)) < LW'(rhs_r);

  // Split c into a signed upper part and an unsigned low word
  assign wcl = $signed({1'b0, wc_r[W-1:0]});
  assign scl = $signed({1'b0, sc_r[W-1:0]});
  assign wch = $signed(wc_r[CW-1:W]);
  assign sch = $signed(sc_r[CW-1:W]);

  // x numerator: c_wall*b_seg - c_seg*b_wall
  assign xwl_nxt = PLW'(wcl) * PLW'(sb3_r);
  assign xsl_nxt = PLW'(scl) * PLW'(wb3_r);
  assign xwh_nxt = PHW'(wch) * PHW'(sb3_r);
  assign xsh_nxt = PHW'(sch) * PHW'(wb3_r);
  // y numerator: a_wall*c_seg - a_seg*c_wall
  assign ywl_nxt = PLW'(wa3_r) * PLW'(scl);
  assign ysl_nxt = PLW'(sa3_r) * PLW'(wcl);
  assign ywh_nxt = PHW'(wa3_r) * PHW'(sch);
  assign ysh_nxt = PHW'(sa3_r) * PHW'(wch);

  logic signed [PLW-1:0] xwl_r, xsl_r, ywl_r, ysl_r;
  logic signed [PHW-1:0] xwh_r, xsh_r, ywh_r, ysh_r;
  logic                  par4_r;
  logic signed [DW-1:0]  det4_r;
  logic [L2W-1:0]        len2_4_r;
  logic signed [W-1:0]   tx4_r, ty4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xwl_r    <= xwl_nxt;
      xsl_r    <= xsl_nxt;
      xwh_r    <= xwh_nxt;
      xsh_r    <= xsh_nxt;
      ywl_r    <= ywl_nxt;
      ysl_r    <= ysl_nxt;
      ywh_r    <= ywh_nxt;
      ysh_r    <= ysh_nxt;
      par4_r   <= par4_nxt;
      det4_r   <= det3_r;
      len2_4_r <= len2_3_r;
      tx4_r    <= tx3_r;
      ty4_r    <= ty3_r;
    end
  end

  // ---------------- Stage 5: assemble numerators
  logic signed [NW-1:0] nx_nxt, ny_nxt;

  assign nx_nxt = ((NW'(xwh_r) - NW'(xsh_r)) <<< W) + NW'(xwl_r) - NW'(xsl_r);
  assign ny_nxt = ((NW'(ywh_r) - NW'(ysh_r)) <<< W) + NW'(ywl_r) - NW'(ysl_r);

  logic signed [NW-1:0] nx_r, ny_r;
  logic                 par5_r;
  logic signed [DW-1:0] det5_r;
  logic [L2W-1:0]       len2_5_r;
  logic signed [W-1:0]  tx5_r, ty5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r     <= nx_nxt;
      ny_r     <= ny_nxt;
      par5_r   <= par4_r;
      det5_r   <= det4_r;
      len2_5_r <= len2_4_r;
      tx5_r    <= tx4_r;
      ty5_r    <= ty4_r;
    end
  end

  assign rec_data = {par5_r, nx_r, ny_r, det5_r, tx5_r, ty5_r, len2_5_r};
endmodule

/* rtl/swi_div.sv */
module swi_div #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int QB    = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QB-1:0]    quo,
  output logic             ovf
);
  localparam int RW = DEN_W + QB + 1;

  logic [RW-1:0]    rem_r [QB+1];
  logic [DEN_W-1:0] den_r [QB+1];
  logic [QB-1:0]    q_r   [QB+1];
  logic             ovf_r [QB+1];

  // Load and flag quotients that do not fit in QB bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(num);
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= RW'(num) >= (RW'(den) << QB);
    end
  end

  // One restoring step per stage, most significant quotient bit first
  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int B = QB - k;
    logic [RW-1:0] shifted;
    logic          fits;
    logic [QB-1:0] q_nxt;

    assign shifted = RW'(den_r[k-1]) << B;
    assign fits    = rem_r[k-1] >= shifted;

    always_comb begin
      q_nxt    = q_r[k-1];
      q_nxt[B] = fits;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= fits ? rem_r[k-1] - shifted : rem_r[k-1];
        den_r[k] <= den_r[k-1];
        q_r[k]   <= q_nxt;
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quo = q_r[QB];
  assign ovf = ovf_r[QB];
endmodule

/* rtl/swi_back.sv */
module swi_back #(
  parameter int COORD_WIDTH = swi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = swi_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       rec_valid,
  output logic                                       rec_ready,
  input  logic [swi_pkg::rec_width(COORD_WIDTH)-1:0] rec_data,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output swi_pkg::status_t                           out_status,
  output logic signed [COORD_WIDTH-1:0]              out_cross_x,
  output logic signed [COORD_WIDTH-1:0]              out_cross_y
);
  import swi_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int DW  = 2 * W + 3;
  localparam int NW  = 3 * W + 4;
  localparam int L2W = 2 * W + 3;
  localparam int QB  = W + 3;
  localparam int QW  = W + 4;
  localparam int EW  = W + 5;
  localparam int E2W = 2 * W + 10;
  localparam int LAT = QB + 1;

  localparam logic [QB-1:0] LIM  = QB'(1) << (W + 2);
  localparam logic [W-1:0]  SENT = W'(sentinel(W, FRAC_BITS));

  logic en;
  logic out_valid_r;

  // One enable for the whole section, released by the output register
  assign en        = !out_valid_r || out_ready;
  assign rec_ready = en;

  // ---------------- Unpack and take magnitudes
  logic                 par_i;
  logic signed [NW-1:0] nx_i, ny_i;
  logic signed [DW-1:0] det_i;
  logic signed [W-1:0]  tx_i, ty_i;
  logic [L2W-1:0]       len2_i;

  assign {par_i, nx_i, ny_i, det_i, tx_i, ty_i, len2_i} = rec_data;

  logic                v0_r;
  logic                par0_r, negx0_r, negy0_r;
  logic [NW-1:0]       nxm_r, nym_r;
  logic [DW-1:0]       detm_r;
  logic signed [W-1:0] tx0_r, ty0_r;
  logic [L2W-1:0]      len2_0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par0_r   <= par_i;
      negx0_r  <= nx_i[NW-1] ^ det_i[DW-1];
      negy0_r  <= ny_i[NW-1] ^ det_i[DW-1];
      nxm_r    <= nx_i[NW-1] ? $unsigned(-nx_i) : $unsigned(nx_i);
      nym_r    <= ny_i[NW-1] ? $unsigned(-ny_i) : $unsigned(ny_i);
      detm_r   <= det_i[DW-1] ? $unsigned(-det_i) : $unsigned(det_i);
      tx0_r    <= tx_i;
      ty0_r    <= ty_i;
      len2_0_r <= len2_i;
    end
  end

  // ---------------- Dividers for both coordinates
  logic [QB-1:0] qx, qy;
  logic          ovx, ovy;

  swi_div #(.NUM_W(NW), .DEN_W(DW), .QB(QB)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (nxm_r),
    .den (detm_r),
    .quo (qx),
    .ovf (ovx)
  );

  swi_div #(.NUM_W(NW), .DEN_W(DW), .QB(QB)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (nym_r),
    .den (detm_r),
    .quo (qy),
    .ovf (ovy)
  );

  // Side data follows the dividers
  logic                sv_r    [LAT];
  logic                spar_r  [LAT];
  logic                snegx_r [LAT];
  logic                snegy_r [LAT];
  logic signed [W-1:0] stx_r   [LAT];
  logic signed [W-1:0] sty_r   [LAT];
  logic [L2W-1:0]      slen2_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        sv_r[i] <= 1'b0;
      end
    end else if (en) begin
      sv_r[0] <= v0_r;
      for (int i = 1; i < LAT; i++) begin
        sv_r[i] <= sv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spar_r[0]  <= par0_r;
      snegx_r[0] <= negx0_r;
      snegy_r[0] <= negy0_r;
      stx_r[0]   <= tx0_r;
      sty_r[0]   <= ty0_r;
      slen2_r[0] <= len2_0_r;
      for (int i = 1; i < LAT; i++) begin
        spar_r[i]  <= spar_r[i-1];
        snegx_r[i] <= snegx_r[i-1];
        snegy_r[i] <= snegy_r[i-1];
        stx_r[i]   <= stx_r[i-1];
        sty_r[i]   <= sty_r[i-1];
        slen2_r[i] <= slen2_r[i-1];
      end
    end
  end

  // ---------------- Clamp quotients, offsets from the second point, saturate
  logic [QB-1:0]        qmx, qmy;
  logic signed [QW-1:0] qcx, qcy;
  logic signed [EW-1:0] ex_nxt, ey_nxt;
  logic [W-1:0]         satx_nxt, saty_nxt;
  logic                 fitx, fity;

  assign qmx = (ovx || qx > LIM) ? LIM : qx;
  assign qmy = (ovy || qy > LIM) ? LIM : qy;
  assign qcx = snegx_r[LAT-1] ? -$signed({1'b0, qmx}) : $signed({1'b0, qmx});
  assign qcy = snegy_r[LAT-1] ? -$signed({1'b0, qmy}) : $signed({1'b0, qmy});

  assign ex_nxt = EW'(qcx) - EW'(stx_r[LAT-1]);
  assign ey_nxt = EW'(qcy) - EW'(sty_r[LAT-1]);

  // In range when all bits above the coordinate sign agree with it
  assign fitx = (&qcx[QW-1:W-1]) || !(|qcx[QW-1:W-1]);
  assign fity = (&qcy[QW-1:W-1]) || !(|qcy[QW-1:W-1]);
  assign satx_nxt = fitx ? qcx[W-1:0] :
                    (qcx[QW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
  assign saty_nxt = fity ? qcy[W-1:0] :
                    (qcy[QW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

  logic                 v1_r, par1_r;
  logic signed [EW-1:0] ex_r, ey_r;
  logic [W-1:0]         satx1_r, saty1_r;
  logic [L2W-1:0]       len2_1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= sv_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par1_r   <= spar_r[LAT-1];
      ex_r     <= ex_nxt;
      ey_r     <= ey_nxt;
      satx1_r  <= satx_nxt;
      saty1_r  <= saty_nxt;
      len2_1_r <= slen2_r[LAT-1];
    end
  end

  // ---------------- Squares of the offsets
  logic signed [E2W-1:0] ex2_nxt, ey2_nxt;

  assign ex2_nxt = E2W'(ex_r) * E2W'(ex_r);
  assign ey2_nxt = E2W'(ey_r) * E2W'(ey_r);

  logic                  v2_r, par2_r;
  logic signed [E2W-1:0] ex2_r, ey2_r;
  logic [W-1:0]          satx2_r, saty2_r;
  logic [L2W-1:0]        len2_2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par2_r   <= par1_r;
      ex2_r    <= ex2_nxt;
      ey2_r    <= ey2_nxt;
      satx2_r  <= satx1_r;
      saty2_r  <= saty1_r;
      len2_2_r <= len2_1_r;
    end
  end

  // ---------------- Reach test and output register
  logic [E2W-1:0] d2;
  status_t        status_nxt;

  assign d2 = $unsigned(ex2_r) + $unsigned(ey2_r);

  always_comb begin
    if (par2_r) begin
      status_nxt = ST_PARALLEL;
    end else if (d2 > E2W'(len2_2_r)) begin
      status_nxt = ST_BEYOND;
    end else begin
      status_nxt = ST_HIT;
    end
  end

  status_t      status_r;
  logic [W-1:0] cross_x_r, cross_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r  <= status_nxt;
      cross_x_r <= (status_nxt == ST_HIT) ? satx2_r : SENT;
      cross_y_r <= (status_nxt == ST_HIT) ? saty2_r : SENT;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_cross_x = $signed(cross_x_r);
  assign out_cross_y = $signed(cross_y_r);
endmodule

/* sim/segment_wall_intersection_test.sv */
`timescale 1ns / 100ps

module segment_wall_intersection_test;
  import swi_pkg::*;

  localparam int W = 32;
  localparam int FB = 16;
  localparam int TAIL_CYCLES = 80;
  localparam int STALL_LIMIT = 20000;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [W-1:0] coord_t;

  typedef struct packed {
    coord_t fx;
    coord_t fy;
    coord_t tx;
    coord_t ty;
  } segment_t;

  typedef struct packed {
    status_t st;
    coord_t  cx;
    coord_t  cy;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  swi_in_if  #(.W(W)) in_chan ();
  swi_out_if #(.W(W)) out_chan ();
  swi_cfg_if #(.W(W)) cfg_chan ();

  segment_wall_intersection #(.COORD_WIDTH(W), .FRAC_BITS(FB)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  always #5 clk = ~clk;

  // Wall copy used by the predictor
  coord_t wall_sx = '0, wall_sy = '0, wall_ex = '0, wall_ey = '0;

  segment_t  pending_segs[$];
  crossing_t expected_crossings[$];

  int send_idle_pct = 32;
  int recv_idle_pct = 80;
  int hold_request = 0;
  int hold_left = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_hit = 0, n_par = 0, n_beyond = 0;

  function automatic wide_t abs_w(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic wide_t clamp_w(input wide_t v, input wide_t lo, input wide_t hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Turn two points into a*x + b*y = c, with the scale s of the normal form
  function automatic void line_of(input wide_t x1, input wide_t y1, input wide_t x2,
                                  input wide_t y2, output wide_t a, output wide_t b,
                                  output wide_t c, output wide_t s);
    wide_t dx, dy;
    dx = x2 - x1;
    dy = y2 - y1;
    if (dx == 0) begin
      a = -1;
      b = 0;
      c = -x2;
      s = 1;
    end else begin
      a = -dy;
      b = dx;
      c = dx * y2 - dy * x2;
      s = dx;
    end
  endfunction

  function automatic crossing_t predict_crossing(input segment_t sg);
    wide_t wa, wb, wc, ws, sa, sb, sc, ss;
    wide_t fx, fy, tx, ty, det, qx, qy, ex, ey, sx, sy, lim, hi, lo;
    crossing_t r;
    fx = sg.fx; fy = sg.fy; tx = sg.tx; ty = sg.ty;
    line_of(wall_sx, wall_sy, wall_ex, wall_ey, wa, wb, wc, ws);
    line_of(fx, fy, tx, ty, sa, sb, sc, ss);
    det = wa * sb - wb * sa;
    r.st = ST_HIT;
    if (abs_w(det) * 1000000 < abs_w(ws * ss)) begin
      r.st = ST_PARALLEL;
    end else begin
      qx = (wc * sb - sc * wb) / det;
      qy = (wa * sc - sa * wc) / det;
      lim = wide_t'(1) <<< (W + 2);
      ex = clamp_w(qx, -lim, lim) - tx;
      ey = clamp_w(qy, -lim, lim) - ty;
      sx = tx - fx;
      sy = ty - fy;
      if (ex * ex + ey * ey > sx * sx + sy * sy) r.st = ST_BEYOND;
    end
    if (r.st != ST_HIT) begin
      r.cx = coord_t'(SENTINEL_UNITS <<< FB);
      r.cy = coord_t'(SENTINEL_UNITS <<< FB);
    end else begin
      hi = (wide_t'(1) <<< (W - 1)) - 1;
      lo = -(wide_t'(1) <<< (W - 1));
      r.cx = coord_t'(clamp_w(qx, lo, hi));
      r.cy = coord_t'(clamp_w(qy, lo, hi));
    end
    return r;
  endfunction

  // Feed the input channel from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.from_x <= '0;
      in_chan.from_y <= '0;
      in_chan.to_x <= '0;
      in_chan.to_y <= '0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (pending_segs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        segment_t sg;
        sg = pending_segs.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.from_x <= sg.fx;
        in_chan.from_y <= sg.fy;
        in_chan.to_x <= sg.tx;
        in_chan.to_y <= sg.ty;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Drive result ready; a hold request stalls it for a long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_request > 0) begin
      hold_left <= hold_request;
      hold_request <= 0;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict on input transfer, check on result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        expected_crossings.push_back(predict_crossing(
          '{in_chan.from_x, in_chan.from_y, in_chan.to_x, in_chan.to_y}));
        n_sent++;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_crossings.size() == 0) begin
          $error("result with nothing expected: status %0d x %0h y %0h",
                 out_chan.status, out_chan.cross_x, out_chan.cross_y);
          errors++;
        end else begin
          crossing_t e;
          e = expected_crossings.pop_front();
          n_checked++;
          case (e.st)
            ST_HIT:      n_hit++;
            ST_PARALLEL: n_par++;
            default:     n_beyond++;
          endcase
          if (out_chan.status !== e.st) begin
            $error("status: expected %0d, actual %0d", e.st, out_chan.status);
            errors++;
          end
          if (out_chan.cross_x !== e.cx) begin
            $error("cross_x: expected %0h, actual %0h", e.cx, out_chan.cross_x);
            errors++;
          end
          if (out_chan.cross_y !== e.cy) begin
            $error("cross_y: expected %0h, actual %0h", e.cy, out_chan.cross_y);
            errors++;
          end
        end
      end
    end
  end

  // End the run when nothing moves for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d results still expected", expected_crossings.size());
      $display("segment_wall_intersection_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every item is sent and every result is in, then let the pipe settle
  task automatic drain();
    while (pending_segs.size() > 0 || in_chan.valid || expected_crossings.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input coord_t val);
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    case (idx)
      REG_WALL_SX: wall_sx = val;
      REG_WALL_SY: wall_sy = val;
      REG_WALL_EX: wall_ex = val;
      default:     wall_ey = val;
    endcase
  endtask

  task automatic set_wall(input coord_t sx, input coord_t sy, input coord_t ex, input coord_t ey);
    write_reg(REG_WALL_SX, sx);
    write_reg(REG_WALL_SY, sy);
    write_reg(REG_WALL_EX, ex);
    write_reg(REG_WALL_EY, ey);
  endtask

  function automatic coord_t near_coord(input int units);
    return coord_t'($signed($urandom_range(2 * units * 65536)) - units * 65536);
  endfunction

  // Mostly segments near the origin, some parallel, degenerate or full-range noise
  function automatic segment_t random_segment();
    segment_t sg;
    int k;
    coord_t dx, dy;
    sg.fx = near_coord(20);
    sg.fy = near_coord(20);
    sg.tx = near_coord(20);
    sg.ty = near_coord(20);
    case ($urandom_range(9))
      0: sg = {$urandom, $urandom, $urandom, $urandom};
      1: begin
        k = $urandom_range(4);
        dx = (wall_ex - wall_sx) >>> k;
        dy = (wall_ey - wall_sy) >>> k;
        sg.tx = sg.fx + dx;
        sg.ty = sg.fy + dy;
      end
      2: begin
        sg.tx = sg.fx;
        sg.ty = sg.fy;
      end
      3: sg.tx = sg.fx;
      4: sg.ty = sg.fy;
      5: begin
        sg.fx = near_coord(2000);
        sg.fy = near_coord(2000);
      end
      default: ;
    endcase
    return sg;
  endfunction

  task automatic queue_random(input int count);
    repeat (count) pending_segs.push_back(random_segment());
  endtask

  localparam coord_t CMAX = {1'b0, {(W-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(W-1){1'b0}}};
  localparam coord_t ONE = coord_t'(1 <<< FB);

  initial begin
    in_chan.valid = 1'b0;
    in_chan.from_x = '0;
    in_chan.from_y = '0;
    in_chan.to_x = '0;
    in_chan.to_y = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = REG_WALL_SX;
    cfg_chan.data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: wall at reset is a point at the origin (vertical line x = 0)
    pending_segs.push_back('{-ONE, '0, ONE, '0});
    pending_segs.push_back('{-ONE, ONE, ONE, ONE});
    pending_segs.push_back('{ONE, -ONE, ONE, ONE});
    pending_segs.push_back('{5 * ONE, '0, 3 * ONE, '0});
    pending_segs.push_back('{CMIN, CMIN, CMAX, CMAX});
    pending_segs.push_back('{CMAX, CMIN, CMIN, CMAX});
    pending_segs.push_back('{CMAX, CMAX, CMAX, CMAX});
    pending_segs.push_back('{'0, '0, '0, '0});
    drain();

    // Directed: horizontal wall y = 0 from -10 to 10
    set_wall(-10 * ONE, '0, 10 * ONE, '0);
    pending_segs.push_back('{ONE, ONE, ONE, -ONE});
    pending_segs.push_back('{'0, 5 * ONE, ONE, 4 * ONE});
    pending_segs.push_back('{'0, ONE, 4 * ONE, ONE});
    pending_segs.push_back('{'0, ONE, 4 * ONE, ONE + 1});
    pending_segs.push_back('{'0, 1, CMAX, 2});
    pending_segs.push_back('{CMIN, CMAX, CMAX, CMIN});
    pending_segs.push_back('{2 * ONE, 3 * ONE, 2 * ONE, 3 * ONE});
    pending_segs.push_back('{CMIN, 1, CMIN + 1, 2});
    pending_segs.push_back('{CMAX, CMIN, CMAX, CMIN + 1});
    queue_random(150);
    drain();

    // Long receiver stall while the sender keeps offering
    hold_request = 400;
    queue_random(60);
    drain();

    // Swap idling sides
    send_idle_pct = 80;
    recv_idle_pct = 32;
    set_wall(5 * ONE, -5 * ONE, 5 * ONE, 5 * ONE);
    queue_random(150);
    drain();
    set_wall(CMIN, CMIN, CMAX, CMAX);
    queue_random(150);
    drain();

    // No idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_wall(CMAX, CMIN, CMIN, CMAX);
    queue_random(130);
    drain();
    set_wall(-3 * ONE, 7 * ONE, 11 * ONE, -2 * ONE + 12345);
    queue_random(130);
    drain();
    set_wall(ONE, ONE, ONE, ONE);
    queue_random(100);
    drain();

    $display("covered %0d segments against 7 wall settings: %0d hits, %0d parallel, %0d beyond",
             n_sent, n_hit, n_par, n_beyond);
    $display("%0d results checked, %0d mismatches", n_checked, errors);
    if (errors == 0 && expected_crossings.size() == 0) begin
      $display("segment_wall_intersection_test passed");
    end else begin
      $display("segment_wall_intersection_test failed");
    end
    $finish;
  end

endmodule
